[src/pbv_pkg.sv]
// Shared types and constants of the packed bit-field store.
package pbv_pkg;

  // Default sizes of the store.
  localparam int unsigned MAX_FIELDS_DEF = 64;
  localparam int unsigned MAX_WORDS_DEF  = 64;
  localparam int unsigned WORD_BITS_DEF  = 64;

  // Fixed widths of the request and result fields.
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned INDEX_W = 6;
  // A computed field width runs from 0 to DATA_W.
  localparam int unsigned WIDTH_W = $clog2(DATA_W + 1);

  // The width finder scans the range one byte per cycle.
  localparam int unsigned CHUNK_W     = 8;
  localparam int unsigned CHUNK_CNT   = DATA_W / CHUNK_W;
  localparam int unsigned CHUNK_SEL_W = $clog2(CHUNK_CNT);
  localparam int unsigned CHUNK_POS_W = $clog2(CHUNK_W);

  typedef enum logic [1:0] {
    ACT_DEFINE = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_INDEX = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_BAD_RANGE = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WIDTH,
    S_TAB,
    S_WORD
  } state_t;

  typedef struct packed {
    action_t             action;
    logic [DATA_W-1:0]   field_range;
    logic [INDEX_W-1:0]  field_index;
    logic [DATA_W-1:0]   field_value;
  } in_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    status_t           status;
  } out_rsp_t;

  // Result of the width finder.
  typedef struct packed {
    logic               done;
    logic [WIDTH_W-1:0] bits;
  } wid_rsp_t;

  // Access request to one of the memories.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_cmd_t;

endpackage

[src/pbv_width.sv]
// Iterative unit that finds the bit width needed for a field range.
module pbv_width (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pbv_pkg::DATA_W-1:0]   range_in,
  output pbv_pkg::wid_rsp_t            rsp
);

  logic                                busy_r, busy_nxt;
  logic [pbv_pkg::CHUNK_SEL_W-1:0]     cnt_r, cnt_nxt;
  logic [pbv_pkg::DATA_W-1:0]          x_r, x_nxt;
  pbv_pkg::wid_rsp_t                   rsp_r, rsp_nxt;
  logic [pbv_pkg::CHUNK_W-1:0]         chunk;
  logic [pbv_pkg::CHUNK_POS_W-1:0]     top_bit;
  logic                                hit;

  // Highest set bit of the byte under scan.
  always_comb begin
    chunk   = x_r[cnt_r*pbv_pkg::CHUNK_W +: pbv_pkg::CHUNK_W];
    hit     = |chunk;
    top_bit = '0;
    for (int i = 0; i < int'(pbv_pkg::CHUNK_W); i++) begin
      if (chunk[i]) begin
        top_bit = pbv_pkg::CHUNK_POS_W'(i);
      end
    end
  end

  // Scan range minus one from the top byte down; the width is one above
  // its highest set bit, or zero when it is all zero.
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    rsp_nxt  = '0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = pbv_pkg::CHUNK_SEL_W'(pbv_pkg::CHUNK_CNT - 1);
      x_nxt    = range_in - pbv_pkg::DATA_W'(1);
    end else if (busy_r) begin
      if (hit) begin
        rsp_nxt.done = 1'b1;
        rsp_nxt.bits = pbv_pkg::WIDTH_W'({cnt_r, top_bit}) + pbv_pkg::WIDTH_W'(1);
        busy_nxt     = 1'b0;
      end else if (cnt_r == '0) begin
        rsp_nxt.done = 1'b1;
        busy_nxt     = 1'b0;
      end else begin
        cnt_nxt = cnt_r - pbv_pkg::CHUNK_SEL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      rsp_r.done  <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      rsp_r.done  <= rsp_nxt.done;
    end
    rsp_r.bits <= rsp_nxt.bits;
    cnt_r      <= cnt_nxt;
    x_r        <= x_nxt;
  end

  assign rsp = rsp_r;

endmodule

[src/pbv_field_tab.sv]
// Field table memory: range and placement of each defined field.
module pbv_field_tab #(
  parameter int unsigned DEPTH = pbv_pkg::MAX_FIELDS_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int unsigned PW    = 18
) (
  input  logic                        clk,
  input  pbv_pkg::mem_cmd_t           cmd,
  input  logic [AW-1:0]               addr,
  input  logic [pbv_pkg::DATA_W-1:0]  wr_limit,
  input  logic [PW-1:0]               wr_place,
  output logic [pbv_pkg::DATA_W-1:0]  rd_limit,
  output logic [PW-1:0]               rd_place
);

  logic [pbv_pkg::DATA_W-1:0] limit_mem [DEPTH];
  logic [PW-1:0]              place_mem [DEPTH];

  // One access a cycle; read data is registered and holds until the next read.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      limit_mem[addr] <= wr_limit;
      place_mem[addr] <= wr_place;
    end
    if (cmd.rd_en) begin
      rd_limit <= limit_mem[addr];
      rd_place <= place_mem[addr];
    end
  end

endmodule

[src/pbv_word_mem.sv]
// Packed word memory.
module pbv_word_mem #(
  parameter int unsigned DEPTH = pbv_pkg::MAX_WORDS_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int unsigned WB    = pbv_pkg::WORD_BITS_DEF
) (
  input  logic              clk,
  input  pbv_pkg::mem_cmd_t cmd,
  input  logic [AW-1:0]     addr,
  input  logic [WB-1:0]     wr_data,
  output logic [WB-1:0]     rd_data
);

  logic [WB-1:0] word_mem [DEPTH];

  // Single port with a registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      word_mem[addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= word_mem[addr];
    end
  end

endmodule

[src/packed_bitfield_vector_store.sv]
// Top level of the packed bit-field store: sequencer and field insert/extract.
//
//   channel  ports                        handshake
//   request  in_req                       start, accepted when busy is low
//   result   out_rsp                      out_valid, one cycle, no back-pressure
//
// A bad index or a zero range answers in the cycle after the request is taken.
// Write and read go through a field table read, a word read, then the result;
// a value that is too large or a width-zero field answers after the table read.
// Define waits on the byte-per-cycle width finder for its result.
// Clear, and the pass that follows reset, sweep the word memory one word a
// cycle over all MAX_WORDS words with busy high; clear answers after its sweep.
// Results are never stalled; a new request may be taken while one is shown.
module packed_bitfield_vector_store #(
  parameter int unsigned MAX_FIELDS = pbv_pkg::MAX_FIELDS_DEF,
  parameter int unsigned MAX_WORDS  = pbv_pkg::MAX_WORDS_DEF,
  parameter int unsigned WORD_BITS  = pbv_pkg::WORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pbv_pkg::in_req_t  in_req,
  output logic              out_valid,
  output pbv_pkg::out_rsp_t out_rsp
);

  localparam int unsigned FTAW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int unsigned WAW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned FDW  = $clog2(MAX_FIELDS + 1);
  localparam int unsigned WUW  = $clog2(MAX_WORDS + 1);
  localparam int unsigned BLW  = $clog2(WORD_BITS + 1);
  localparam int unsigned OFW  = $clog2(WORD_BITS);
  localparam int unsigned PW   = WAW + OFW + BLW;
  localparam int unsigned CW0  = (FDW > FTAW) ? FDW : FTAW;
  localparam int unsigned CMPW = (CW0 > pbv_pkg::INDEX_W) ? CW0 : pbv_pkg::INDEX_W;

  pbv_pkg::state_t             state_r, state_nxt;
  pbv_pkg::in_req_t            req_r;
  logic [FDW-1:0]              fields_defined_r, fields_defined_nxt;
  logic [WUW-1:0]              words_used_r, words_used_nxt;
  logic [BLW-1:0]              bits_left_r, bits_left_nxt;
  logic [WAW-1:0]              clr_cnt_r, clr_cnt_nxt;
  logic                        clr_rsp_r, clr_rsp_nxt;
  logic                        out_valid_r, out_valid_nxt;
  pbv_pkg::out_rsp_t           out_rsp_r, out_rsp_nxt;

  logic                        accept;
  logic                        wid_start;
  pbv_pkg::wid_rsp_t           wid_rsp;
  pbv_pkg::mem_cmd_t           tab_cmd, word_cmd;
  logic [FTAW-1:0]             tab_addr;
  logic [PW-1:0]               tab_wr_place;
  logic [pbv_pkg::DATA_W-1:0]  tab_rd_limit;
  logic [PW-1:0]               tab_rd_place;
  logic [WAW-1:0]              word_addr;
  logic [WORD_BITS-1:0]        word_wr_data, word_rd_data;

  // Request decode.
  logic [CMPW-1:0]             idx_ext;
  logic [FTAW-1:0]             idx_addr, fd_addr;
  logic                        idx_bad, range_zero;

  // Define placement.
  logic                        too_wide, tab_full, need_new, words_full;
  logic [WUW-1:0]              wu_new;
  logic [BLW-1:0]              bl_new, def_bits;
  logic [WAW-1:0]              def_word;
  logic [OFW-1:0]              def_off;

  // Field access.
  logic [WAW-1:0]              t_word;
  logic [OFW-1:0]              t_off;
  logic [BLW-1:0]              t_bits;
  logic                        is_write, too_large, need_word;
  logic [WORD_BITS:0]          ones_full;
  logic [WORD_BITS-1:0]        field_mask, new_word, extract;

  // The width finder loads the range in the cycle the request is taken.
  pbv_width u_width (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (wid_start),
    .range_in (in_req.field_range),
    .rsp      (wid_rsp)
  );

  pbv_field_tab #(
    .DEPTH (MAX_FIELDS),
    .AW    (FTAW),
    .PW    (PW)
  ) u_field_tab (
    .clk      (clk),
    .cmd      (tab_cmd),
    .addr     (tab_addr),
    .wr_limit (req_r.field_range),
    .wr_place (tab_wr_place),
    .rd_limit (tab_rd_limit),
    .rd_place (tab_rd_place)
  );

  pbv_word_mem #(
    .DEPTH (MAX_WORDS),
    .AW    (WAW),
    .WB    (WORD_BITS)
  ) u_word_mem (
    .clk     (clk),
    .cmd     (word_cmd),
    .addr    (word_addr),
    .wr_data (word_wr_data),
    .rd_data (word_rd_data)
  );

  assign accept = start && (state_r == pbv_pkg::S_IDLE);
  assign busy   = (state_r != pbv_pkg::S_IDLE);

  // Index and range checks on the incoming request.
  always_comb begin
    idx_ext    = CMPW'(in_req.field_index);
    idx_addr   = idx_ext[FTAW-1:0];
    fd_addr    = fields_defined_r[FTAW-1:0];
    idx_bad    = (idx_ext >= CMPW'(fields_defined_r)) || (idx_ext >= CMPW'(MAX_FIELDS));
    range_zero = (in_req.field_range == '0);
  end

  // Placement of a new field once its width is known.
  always_comb begin
    too_wide   = wid_rsp.bits > pbv_pkg::WIDTH_W'(WORD_BITS);
    tab_full   = fields_defined_r >= FDW'(MAX_FIELDS);
    need_new   = pbv_pkg::WIDTH_W'(bits_left_r) < wid_rsp.bits;
    words_full = words_used_r >= WUW'(MAX_WORDS);
    wu_new     = need_new ? (words_used_r + WUW'(1)) : words_used_r;
    bl_new     = need_new ? BLW'(WORD_BITS) : bits_left_r;
    def_bits   = BLW'(wid_rsp.bits);
    def_word   = ((def_bits == '0) || (wu_new == '0)) ? '0 : WAW'(wu_new - WUW'(1));
    def_off    = (def_bits == '0) ? '0 : OFW'(BLW'(WORD_BITS) - bl_new);
    tab_wr_place = {def_word, def_off, def_bits};
  end

  // Insert and extract of the field that the table read returned.
  always_comb begin
    {t_word, t_off, t_bits} = tab_rd_place;
    is_write   = (req_r.action == pbv_pkg::ACT_WRITE);
    too_large  = req_r.field_value >= tab_rd_limit;
    need_word  = (t_bits != '0) && !(is_write && too_large);
    ones_full  = ((WORD_BITS+1)'(1) << t_bits) - (WORD_BITS+1)'(1);
    field_mask = ones_full[WORD_BITS-1:0] << t_off;
    extract    = (word_rd_data >> t_off) & ones_full[WORD_BITS-1:0];
    new_word   = (word_rd_data & ~field_mask)
               | ((req_r.field_value[WORD_BITS-1:0] << t_off) & field_mask);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pbv_pkg::S_CLEAR: begin
        if (clr_cnt_r == WAW'(MAX_WORDS - 1)) begin
          state_nxt = pbv_pkg::S_IDLE;
        end
      end
      pbv_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_req.action) inside
            pbv_pkg::ACT_DEFINE: state_nxt = range_zero ? pbv_pkg::S_IDLE : pbv_pkg::S_WIDTH;
            pbv_pkg::ACT_CLEAR:  state_nxt = pbv_pkg::S_CLEAR;
            pbv_pkg::ACT_WRITE, pbv_pkg::ACT_READ:
              state_nxt = idx_bad ? pbv_pkg::S_IDLE : pbv_pkg::S_TAB;
            default:             state_nxt = pbv_pkg::S_IDLE;
          endcase
        end
      end
      pbv_pkg::S_WIDTH: begin
        if (wid_rsp.done) begin
          state_nxt = pbv_pkg::S_IDLE;
        end
      end
      pbv_pkg::S_TAB:  state_nxt = need_word ? pbv_pkg::S_WORD : pbv_pkg::S_IDLE;
      pbv_pkg::S_WORD: state_nxt = pbv_pkg::S_IDLE;
      default:         state_nxt = pbv_pkg::S_IDLE;
    endcase
  end

  // Memory requests, counter updates and results.
  always_comb begin
    wid_start          = 1'b0;
    tab_cmd            = '0;
    tab_addr           = idx_addr;
    word_cmd           = '0;
    word_addr          = t_word;
    word_wr_data       = new_word;
    fields_defined_nxt = fields_defined_r;
    words_used_nxt     = words_used_r;
    bits_left_nxt      = bits_left_r;
    clr_cnt_nxt        = clr_cnt_r;
    clr_rsp_nxt        = clr_rsp_r;
    out_valid_nxt      = 1'b0;
    out_rsp_nxt        = '{read_value: '0, status: pbv_pkg::ST_OK};
    unique case (state_r)
      pbv_pkg::S_CLEAR: begin
        // Zero one word per cycle.
        word_cmd.wr_en = 1'b1;
        word_addr      = clr_cnt_r;
        word_wr_data   = '0;
        clr_cnt_nxt    = clr_cnt_r + WAW'(1);
        if (clr_cnt_r == WAW'(MAX_WORDS - 1)) begin
          clr_cnt_nxt   = '0;
          clr_rsp_nxt   = 1'b0;
          out_valid_nxt = clr_rsp_r;
        end
      end
      pbv_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_req.action) inside
            pbv_pkg::ACT_DEFINE: begin
              if (range_zero) begin
                out_valid_nxt      = 1'b1;
                out_rsp_nxt.status = pbv_pkg::ST_BAD_RANGE;
              end else begin
                wid_start = 1'b1;
              end
            end
            pbv_pkg::ACT_CLEAR: begin
              clr_cnt_nxt = '0;
              clr_rsp_nxt = 1'b1;
            end
            pbv_pkg::ACT_WRITE, pbv_pkg::ACT_READ: begin
              if (idx_bad) begin
                out_valid_nxt      = 1'b1;
                out_rsp_nxt.status = pbv_pkg::ST_BAD_INDEX;
              end else begin
                tab_cmd.rd_en = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b0;
            end
          endcase
        end
      end
      pbv_pkg::S_WIDTH: begin
        // Checks go range first, then the field table, then the words.
        tab_addr = fd_addr;
        if (wid_rsp.done) begin
          out_valid_nxt = 1'b1;
          if (too_wide) begin
            out_rsp_nxt.status = pbv_pkg::ST_BAD_RANGE;
          end else if (tab_full || (need_new && words_full)) begin
            out_rsp_nxt.status = pbv_pkg::ST_FULL;
          end else begin
            tab_cmd.wr_en      = 1'b1;
            fields_defined_nxt = fields_defined_r + FDW'(1);
            words_used_nxt     = wu_new;
            bits_left_nxt      = bl_new - def_bits;
          end
        end
      end
      pbv_pkg::S_TAB: begin
        if (need_word) begin
          word_cmd.rd_en = 1'b1;
        end else begin
          out_valid_nxt = 1'b1;
          if (is_write && too_large) begin
            out_rsp_nxt.status = pbv_pkg::ST_TOO_LARGE;
          end
        end
      end
      pbv_pkg::S_WORD: begin
        out_valid_nxt = 1'b1;
        if (is_write) begin
          word_cmd.wr_en = 1'b1;
        end else begin
          out_rsp_nxt.read_value = pbv_pkg::DATA_W'(extract);
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= pbv_pkg::S_CLEAR;
      fields_defined_r <= '0;
      words_used_r     <= '0;
      bits_left_r      <= '0;
      clr_cnt_r        <= '0;
      clr_rsp_r        <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      fields_defined_r <= fields_defined_nxt;
      words_used_r     <= words_used_nxt;
      bits_left_r      <= bits_left_nxt;
      clr_cnt_r        <= clr_cnt_nxt;
      clr_rsp_r        <= clr_rsp_nxt;
      out_valid_r      <= out_valid_nxt;
    end
    out_rsp_r <= out_rsp_nxt;
    if (accept) begin
      req_r <= in_req;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

`ifndef SYNTH
  // A taken request either keeps the block busy or answers in the next cycle.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted request neither in progress nor answered");

  // A result comes only from work in progress or from a request just taken.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result without a request");

  // Allocation counters stay within the store.
  a_counts_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fields_defined_r <= FDW'(MAX_FIELDS)) && (words_used_r <= WUW'(MAX_WORDS))
    && (bits_left_r <= BLW'(WORD_BITS)))
    else $error("allocation counter out of range");

  // Words are written only by the clearing sweep or a field write.
  a_word_write: assert property (@(posedge clk) disable iff (!rst_n)
    word_cmd.wr_en |-> ((state_r == pbv_pkg::S_CLEAR) || (state_r == pbv_pkg::S_WORD)))
    else $error("word memory written outside sweep or field write");
`endif

endmodule

[sim/tb_packed_bitfield_vector_store.sv]
// Self-checking testbench of the packed bit-field store: directed and random requests.
module tb_packed_bitfield_vector_store;

  localparam int unsigned FIELDS = pbv_pkg::MAX_FIELDS_DEF;
  localparam int unsigned WORDS = pbv_pkg::MAX_WORDS_DEF;
  localparam int unsigned WBITS = pbv_pkg::WORD_BITS_DEF;
  localparam int unsigned DW = pbv_pkg::DATA_W;
  localparam int unsigned RANDOM_REQUESTS = 1020;
  localparam logic [DW-1:0] HALF = 64'h8000_0000_0000_0000;

  // Tracks the field table and packed words, and holds the responses still owed.
  class field_store_tracker;
    int unsigned n_fields;
    int unsigned n_words;
    int unsigned free_bits;
    logic [DW-1:0] limit_of [FIELDS];
    int unsigned word_of [FIELDS];
    int unsigned offset_of [FIELDS];
    int unsigned width_of [FIELDS];
    logic [DW-1:0] store_words [WORDS];
    pbv_pkg::out_rsp_t awaited_answers [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned per_action [4];
    int unsigned per_status [8];

    function new();
      n_fields = 0;
      n_words = 0;
      free_bits = 0;
      errors = 0;
      checked = 0;
      foreach (store_words[i]) store_words[i] = '0;
      foreach (per_action[i]) per_action[i] = 0;
      foreach (per_status[i]) per_status[i] = 0;
    endfunction

    // Smallest width whose value count covers the range.
    function int unsigned width_needed(logic [DW-1:0] lim);
      int unsigned b;
      b = 0;
      while (b < DW && ((DW'(1) << b) < lim)) b++;
      return b;
    endfunction

    function logic [DW-1:0] mask_of(int unsigned idx);
      logic [DW-1:0] ones;
      ones = (width_of[idx] >= DW) ? '1 : ((DW'(1) << width_of[idx]) - DW'(1));
      return ones << offset_of[idx];
    endfunction

    // Appends a field; it never straddles a word, so it may open a fresh one.
    function pbv_pkg::status_t define_status(logic [DW-1:0] lim);
      int unsigned bits;
      if (lim == '0) return pbv_pkg::ST_BAD_RANGE;
      bits = width_needed(lim);
      if (bits > WBITS) return pbv_pkg::ST_BAD_RANGE;
      if (n_fields >= FIELDS) return pbv_pkg::ST_FULL;
      if (free_bits < bits) begin
        if (n_words >= WORDS) return pbv_pkg::ST_FULL;
        n_words++;
        free_bits = WBITS;
      end
      width_of[n_fields] = bits;
      word_of[n_fields] = (bits == 0 || n_words == 0) ? 0 : n_words - 1;
      offset_of[n_fields] = (bits == 0) ? 0 : WBITS - free_bits;
      free_bits -= bits;
      limit_of[n_fields] = lim;
      n_fields++;
      return pbv_pkg::ST_OK;
    endfunction

    // Applies an accepted request and queues the response it must produce.
    function void take_request(pbv_pkg::in_req_t r);
      pbv_pkg::out_rsp_t ans;
      int unsigned idx;
      int unsigned w;
      logic [DW-1:0] m;
      ans.read_value = '0;
      ans.status = pbv_pkg::ST_OK;
      idx = 32'(r.field_index);
      per_action[int'(r.action)]++;
      case (r.action)
        pbv_pkg::ACT_DEFINE: ans.status = define_status(r.field_range);
        pbv_pkg::ACT_CLEAR: foreach (store_words[i]) store_words[i] = '0;
        default: begin
          if (idx >= n_fields) begin
            ans.status = pbv_pkg::ST_BAD_INDEX;
          end else begin
            m = mask_of(idx);
            w = word_of[idx];
            if (r.action == pbv_pkg::ACT_WRITE) begin
              if (r.field_value >= limit_of[idx]) begin
                ans.status = pbv_pkg::ST_TOO_LARGE;
              end else if (width_of[idx] != 0) begin
                store_words[w] = (store_words[w] & ~m)
                               | ((r.field_value << offset_of[idx]) & m);
              end
            end else if (width_of[idx] != 0) begin
              ans.read_value = (store_words[w] & m) >> offset_of[idx];
            end
          end
        end
      endcase
      per_status[int'(ans.status)]++;
      awaited_answers = {awaited_answers, ans};
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    // Compares one response with the oldest one owed.
    function void check_response(pbv_pkg::out_rsp_t got);
      pbv_pkg::out_rsp_t want;
      if (awaited_answers.size() == 0) begin
        flag($sformatf("response with no request waiting: value %h status %0d",
                       got.read_value, got.status));
        return;
      end
      want = awaited_answers[0];
      awaited_answers.delete(0);
      checked++;
      if (got.read_value !== want.read_value)
        flag($sformatf("read_value expected %h, got %h", want.read_value, got.read_value));
      if (got.status !== want.status)
        flag($sformatf("status expected %0d, got %0d", want.status, got.status));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  pbv_pkg::in_req_t in_req;
  logic out_valid;
  pbv_pkg::out_rsp_t out_rsp;
  logic steady = 1'b0;
  field_store_tracker board = new();

  always #1 clk = ~clk;

  packed_bitfield_vector_store u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  // Every strobed response is checked at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_response(out_rsp);
  end

  function automatic logic [DW-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  function automatic pbv_pkg::in_req_t pack_request(pbv_pkg::action_t a, logic [DW-1:0] lim,
                                                    int unsigned idx, logic [DW-1:0] val);
    pbv_pkg::in_req_t r;
    r.action = a;
    r.field_range = lim;
    r.field_index = pbv_pkg::INDEX_W'(idx);
    r.field_value = val;
    return r;
  endfunction

  // Ranges cluster around powers of two; most are small.
  function automatic logic [DW-1:0] pick_limit();
    logic [DW-1:0] p;
    p = DW'(1) << $urandom_range(0, DW - 1);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return DW'(1);
      2: return p;
      3: return p + DW'(1);
      4: return (p == DW'(1)) ? DW'(2) : p - DW'(1);
      5: return random_word();
      default: return random_word() >> $urandom_range(44, 63);
    endcase
  endfunction

  // Mostly writes and reads of defined fields, with defines, clears and noise mixed in.
  function automatic pbv_pkg::in_req_t make_request();
    pbv_pkg::in_req_t r;
    int unsigned pick;
    int unsigned n;
    int unsigned idx;
    logic [DW-1:0] lim;
    r.field_range = random_word();
    r.field_index = pbv_pkg::INDEX_W'($urandom);
    r.field_value = random_word();
    n = board.n_fields;
    pick = $urandom_range(0, 99);
    if (n == 0 || pick < 10) begin
      r.action = pbv_pkg::ACT_DEFINE;
      r.field_range = pick_limit();
    end else if (pick < 13) begin
      r.action = pbv_pkg::ACT_CLEAR;
    end else begin
      r.action = (pick < 55) ? pbv_pkg::ACT_WRITE : pbv_pkg::ACT_READ;
      if ($urandom_range(0, 9) != 0)
        r.field_index = pbv_pkg::INDEX_W'($urandom_range(0, n - 1));
      idx = 32'(r.field_index);
      if (r.action == pbv_pkg::ACT_WRITE && idx < n) begin
        lim = board.limit_of[idx];
        case ($urandom_range(0, 9))
          0: r.field_value = lim - DW'(1);
          1: r.field_value = lim;
          2: r.field_value = r.field_value;
          default: r.field_value = random_word() % lim;
        endcase
      end
    end
    return r;
  endfunction

  // Holds start high until the request is taken; start is lowered only for a gap.
  task automatic send_request(input pbv_pkg::in_req_t r);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    board.take_request(r);
  endtask

  // Request stimulus and end of run.
  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_req <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty table, constant field, widest fields, word breaks, clear.
    send_request(pack_request(pbv_pkg::ACT_READ, '0, 0, '0));
    send_request(pack_request(pbv_pkg::ACT_WRITE, '0, 63, '1));
    send_request(pack_request(pbv_pkg::ACT_DEFINE, '0, 0, '0));
    send_request(pack_request(pbv_pkg::ACT_DEFINE, 64'd1, 0, '0));
    send_request(pack_request(pbv_pkg::ACT_WRITE, '0, 0, 64'd0));
    send_request(pack_request(pbv_pkg::ACT_WRITE, '0, 0, 64'd1));
    send_request(pack_request(pbv_pkg::ACT_READ, '0, 0, '0));
    send_request(pack_request(pbv_pkg::ACT_DEFINE, '1, 0, '0));
    send_request(pack_request(pbv_pkg::ACT_WRITE, '0, 1, ~64'd1));
    send_request(pack_request(pbv_pkg::ACT_READ, '0, 1, '0));
    send_request(pack_request(pbv_pkg::ACT_DEFINE, 64'd2, 0, '0));
    send_request(pack_request(pbv_pkg::ACT_DEFINE, HALF, 0, '0));
    send_request(pack_request(pbv_pkg::ACT_WRITE, '0, 3, HALF - DW'(1)));
    send_request(pack_request(pbv_pkg::ACT_WRITE, '0, 2, 64'd1));
    send_request(pack_request(pbv_pkg::ACT_READ, '0, 2, '0));
    send_request(pack_request(pbv_pkg::ACT_READ, '0, 3, '0));
    send_request(pack_request(pbv_pkg::ACT_WRITE, '0, 1, '1));
    send_request(pack_request(pbv_pkg::ACT_DEFINE, 64'd3, 0, '0));
    send_request(pack_request(pbv_pkg::ACT_DEFINE, HALF + DW'(1), 0, '0));
    send_request(pack_request(pbv_pkg::ACT_WRITE, '0, 5, HALF));
    send_request(pack_request(pbv_pkg::ACT_READ, '0, 5, '0));
    send_request(pack_request(pbv_pkg::ACT_CLEAR, '0, 0, '0));
    send_request(pack_request(pbv_pkg::ACT_READ, '0, 3, '0));
    send_request(pack_request(pbv_pkg::ACT_READ, '0, 5, '0));
    send_request(pack_request(pbv_pkg::ACT_READ, '0, 6, '0));

    // Random part, with occasional stretches of back-to-back requests.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      send_request(make_request());
    end

    // Fill the field table, then define once more to hit the full table.
    while (board.n_fields < FIELDS)
      send_request(pack_request(pbv_pkg::ACT_DEFINE, 64'd2, 0, '0));
    send_request(pack_request(pbv_pkg::ACT_DEFINE, 64'd5, 0, '0));
    send_request(pack_request(pbv_pkg::ACT_READ, '0, FIELDS - 1, '0));
    start <= 1'b0;

    while (board.awaited_answers.size() != 0) @(posedge clk);
    repeat (WORDS + 16) @(posedge clk);

    $display("Sent %0d defines, %0d writes, %0d reads and %0d clears; %0d responses checked.",
             board.per_action[pbv_pkg::ACT_DEFINE], board.per_action[pbv_pkg::ACT_WRITE],
             board.per_action[pbv_pkg::ACT_READ], board.per_action[pbv_pkg::ACT_CLEAR],
             board.checked);
    $display("Statuses: ok %0d, bad index %0d, too large %0d, bad range %0d, full %0d; %0d errors.",
             board.per_status[pbv_pkg::ST_OK], board.per_status[pbv_pkg::ST_BAD_INDEX],
             board.per_status[pbv_pkg::ST_TOO_LARGE], board.per_status[pbv_pkg::ST_BAD_RANGE],
             board.per_status[pbv_pkg::ST_FULL], board.errors);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: a run that hangs ends here.
  initial begin
    #2000000;
    $display("Timeout: %0d responses still owed.", board.awaited_answers.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[packed_bitfield_vector_store.f]
src/pbv_pkg.sv
src/pbv_width.sv
src/pbv_field_tab.sv
src/pbv_word_mem.sv
src/packed_bitfield_vector_store.sv
sim/tb_packed_bitfield_vector_store.sv
